### sv/okvt_pkg.sv
// shared constants and types for the ordered key-value table
package okvt_pkg;

   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int ENTRY_CNT_W = 5;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]             func;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } op_type;

   // broadcast to every cell in the cycle an operation executes
   typedef struct packed {
      logic                   fire;
      logic [1:0]             func;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
      logic                   found;
   } cmd_type;

endpackage

### sv/ordered_key_value_table_core.sv
// Ordered key-value table of okvt_pkg::DEPTH entries held in a row of cells. Each transaction
// on the req_ side is a lookup, insert/update or remove and yields exactly one rsp_ transaction.
// An accepted operation is registered and executes once the output register can take its
// result: every cell compares its key at once, the match travels down the row to update,
// append or close the gap, and the result lands in an output register. A new operation is
// accepted in the executing cycle, so back-to-back operations sustain one per cycle while
// rsp_tready stays high; a stalled result holds the next operation in place.
module ordered_key_value_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // search_key[31:0], new_value[63:32]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // data_out[31:0], entry_count[36:32], zero pad
   output logic [2:0]  rsp_tuser   // hit[0], status[2:1]
);

   localparam int D  = okvt_pkg::DEPTH;
   localparam int CW = okvt_pkg::COUNT_W;
   localparam int VW = okvt_pkg::VALUE_WIDTH;
   localparam int KW = okvt_pkg::KEY_WIDTH;

   okvt_pkg::op_type  op_ff, op_in;
   okvt_pkg::cmd_type cmd;
   logic              busy_ff, busy_in;
   logic [CW-1:0]     fill_count_ff, fill_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff, hit_in;
   logic [31:0]       data_ff, data_in;
   logic [1:0]        status_ff, status_in;
   logic [okvt_pkg::ENTRY_CNT_W-1:0] count_ff, count_in;

   logic          req_accept, exec_fire, full, found;
   logic [D:0]    seen;
   logic [VW-1:0] hit_value [D+1];
   logic [KW-1:0] cell_key [D];
   logic [VW-1:0] cell_value [D];

   assign exec_fire  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || exec_fire;
   assign req_accept = req_tvalid && req_tready;
   assign full       = (fill_count_ff == CW'(D));

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      if (req_accept) begin
         op_in.func  = req_tuser;
         op_in.key   = req_tdata[KW-1:0];
         op_in.value = req_tdata[32 +: VW];
         busy_in     = 1'b1;
      end else if (exec_fire) begin
         busy_in = 1'b0;
      end
   end

   assign seen[0]      = 1'b0;
   assign hit_value[0] = '0;
   assign found        = seen[D];

   assign cmd.fire  = exec_fire;
   assign cmd.func  = op_ff.func;
   assign cmd.key   = op_ff.key;
   assign cmd.value = op_ff.value;
   assign cmd.found = found;

   for (genvar i = 0; i < D; i++) begin : g_cell
      logic [KW-1:0] nk;
      logic [VW-1:0] nv;
      if (i == D - 1) begin : g_last
         assign nk = '0;
         assign nv = '0;
      end else begin : g_mid
         assign nk = cell_key[i+1];
         assign nv = cell_value[i+1];
      end
      okvt_cell u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .occupied      (CW'(i) < fill_count_ff),
         .tail          (CW'(i) == fill_count_ff),
         .seen_in       (seen[i]),
         .seen_out      (seen[i+1]),
         .hit_value_in  (hit_value[i]),
         .hit_value_out (hit_value[i+1]),
         .next_key      (nk),
         .next_value    (nv),
         .key_q         (cell_key[i]),
         .value_q       (cell_value[i])
      );
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      hit_in        = found;
      data_in       = '0;
      status_in     = okvt_pkg::STATUS_OK;
      unique case (op_ff.func)
         okvt_pkg::FUNC_INSERT: begin
            if (found) begin
               data_in = 32'(op_ff.value);
            end else if (!full) begin
               data_in       = 32'(op_ff.value);
               fill_count_in = fill_count_ff + CW'(1);
            end else begin
               status_in = okvt_pkg::STATUS_FULL;
            end
         end
         okvt_pkg::FUNC_REMOVE: begin
            if (found) begin
               data_in       = 32'(hit_value[D]);
               fill_count_in = fill_count_ff - CW'(1);
            end else begin
               status_in = okvt_pkg::STATUS_NOTFOUND;
            end
         end
         default: begin
            // lookup, and the unused code behaves the same
            if (found) begin
               data_in = 32'(hit_value[D]);
            end else begin
               status_in = okvt_pkg::STATUS_NOTFOUND;
            end
         end
      endcase
      count_in = okvt_pkg::ENTRY_CNT_W'(fill_count_in);
      if (!exec_fire) begin
         fill_count_in = fill_count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (exec_fire) begin
         hit_ff    <= hit_in;
         data_ff   <= data_in;
         status_ff <= status_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, count_ff, data_ff};
   assign rsp_tuser  = {status_ff, hit_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CW'(D))
      else $error("entry count beyond table depth");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == okvt_pkg::STATUS_OK)
      else $error("result with a hit reports a failure status");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      exec_fire && found && op_ff.func == okvt_pkg::FUNC_REMOVE
      |=> fill_count_ff == $past(fill_count_ff) - CW'(1))
      else $error("remove of a present key did not shrink the table");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      exec_fire && status_in == okvt_pkg::STATUS_FULL |=> $stable(fill_count_ff))
      else $error("dropped insert changed the entry count");

endmodule

### sv/okvt_cell.sv
// one table entry: key compare, match chain and shift towards the head
module okvt_cell (
   input  logic                                clock,
   input  okvt_pkg::cmd_type                   cmd,
   input  logic                                occupied,
   input  logic                                tail,
   input  logic                                seen_in,
   output logic                                seen_out,
   input  logic [okvt_pkg::VALUE_WIDTH-1:0]    hit_value_in,
   output logic [okvt_pkg::VALUE_WIDTH-1:0]    hit_value_out,
   input  logic [okvt_pkg::KEY_WIDTH-1:0]      next_key,
   input  logic [okvt_pkg::VALUE_WIDTH-1:0]    next_value,
   output logic [okvt_pkg::KEY_WIDTH-1:0]      key_q,
   output logic [okvt_pkg::VALUE_WIDTH-1:0]    value_q
);

   logic [okvt_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [okvt_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic                             match;
   logic                             is_insert, is_remove;

   assign match         = occupied && (key_ff == cmd.key);
   assign seen_out      = seen_in | match;
   assign hit_value_out = hit_value_in | (match ? value_ff : '0);
   assign is_insert     = cmd.fire && (cmd.func == okvt_pkg::FUNC_INSERT);
   assign is_remove     = cmd.fire && (cmd.func == okvt_pkg::FUNC_REMOVE);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      priority if (is_insert && match) begin
         value_in = cmd.value;
      end else if (is_insert && !cmd.found && tail) begin
         key_in   = cmd.key;
         value_in = cmd.value;
      end else if (is_remove && seen_out) begin
         // every entry from the removed one onwards takes its successor
         key_in   = next_key;
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_q   = key_ff;
   assign value_q = value_ff;

endmodule

### tb/sv/ordered_key_value_table_core_test.sv
// testbench for ordered_key_value_table_core: random and directed operations against a mirror
`timescale 1ns / 100ps

module ordered_key_value_table_core_test;

   // spare func code, executed as a lookup
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE = 24;

   typedef struct packed {
      logic                            hit;
      logic [okvt_pkg::VALUE_WIDTH-1:0] data_out;
      logic [1:0]                      status;
      logic [4:0]                      entry_count;
   } table_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // search_key[31:0], new_value[63:32]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // data_out[31:0], entry_count[36:32], zero pad
   logic [2:0]  rsp_tuser;        // hit[0], status[2:1]

   okvt_pkg::op_type  pending_ops[$];
   table_result_type  results_due[$];
   okvt_pkg::op_type  cur_op;
   int                sent_count = 0;
   int                cycle_count = 0;
   bit                failed = 1'b0;

   // mirror of the table contents
   logic [okvt_pkg::KEY_WIDTH-1:0]   mirror_key[okvt_pkg::DEPTH];
   logic [okvt_pkg::VALUE_WIDTH-1:0] mirror_value[okvt_pkg::DEPTH];
   int                               mirror_fill = 0;

   logic [okvt_pkg::KEY_WIDTH-1:0]   key_pool[POOL_SIZE];

   ordered_key_value_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic table_result_type table_apply(okvt_pkg::op_type op);
      table_result_type res;
      int               slot;
      bit               found;
      res = '0;
      slot = mirror_fill;
      found = 1'b0;
      for (int i = 0; i < mirror_fill; i++) begin
         if (!found && mirror_key[i] == op.key) begin
            found = 1'b1;
            slot = i;
         end
      end
      case (op.func)
         okvt_pkg::FUNC_INSERT: begin
            if (found) begin
               mirror_value[slot] = op.value;
               res.data_out = op.value;
            end else if (mirror_fill < okvt_pkg::DEPTH) begin
               mirror_key[mirror_fill] = op.key;
               mirror_value[mirror_fill] = op.value;
               mirror_fill++;
               res.data_out = op.value;
            end else begin
               res.status = okvt_pkg::STATUS_FULL;
            end
         end
         okvt_pkg::FUNC_REMOVE: begin
            if (found) begin
               res.data_out = mirror_value[slot];
               // close the gap, keeping order
               for (int i = slot; i + 1 < mirror_fill; i++) begin
                  mirror_key[i] = mirror_key[i + 1];
                  mirror_value[i] = mirror_value[i + 1];
               end
               mirror_fill--;
            end else begin
               res.status = okvt_pkg::STATUS_NOTFOUND;
            end
         end
         default: begin
            if (found) res.data_out = mirror_value[slot];
            else res.status = okvt_pkg::STATUS_NOTFOUND;
         end
      endcase
      res.hit = found;
      res.entry_count = mirror_fill[4:0];
      return res;
   endfunction

   // no idling during a middle stretch of the run
   function automatic bit idle_roll();
      return !(sent_count >= 400 && sent_count < 700) && ($urandom_range(99) < 28);
   endfunction

   task automatic push_op(input logic [1:0] f, input logic [31:0] k, input logic [31:0] v);
      okvt_pkg::op_type op;
      op.func = f;
      op.key = k;
      op.value = v;
      pending_ops.push_back(op);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // random operations in bursts that lean towards filling or emptying the table
   task automatic push_random(input int count);
      int          burst_left;
      int          insert_pct;
      int          r;
      logic [1:0]  f;
      logic [31:0] k;
      burst_left = 0;
      insert_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 30);
            insert_pct = $urandom_range(80, 20);
         end
         burst_left--;
         r = $urandom_range(99);
         if (r < 3) f = FUNC_SPARE;
         else if (r < insert_pct) f = okvt_pkg::FUNC_INSERT;
         else if (r[0]) f = okvt_pkg::FUNC_REMOVE;
         else f = okvt_pkg::FUNC_LOOKUP;
         // inserts stay within the pool so removes can always empty the table
         if (f != okvt_pkg::FUNC_INSERT && $urandom_range(99) < 15) k = $urandom;
         else k = key_pool[$urandom_range(POOL_SIZE - 1)];
         push_op(f, k, random_value());
      end
   endtask

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            results_due.push_back(table_apply(cur_op));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && !idle_roll()) begin
               cur_op = pending_ops.pop_front();
               req_tdata <= {cur_op.value, cur_op.key};
               req_tuser <= cur_op.func;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response against the oldest prediction
   always @(posedge clock) begin
      table_result_type want;
      table_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tuser[0];
            got.status = rsp_tuser[2:1];
            got.data_out = rsp_tdata[31:0];
            got.entry_count = rsp_tdata[36:32];
            if (results_due.size() == 0) begin
               $error("response with none outstanding: data_out %0h", got.data_out);
               failed = 1'b1;
            end else begin
               want = results_due.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit expected %0h actual %0h", want.hit, got.hit);
                  failed = 1'b1;
               end
               if (got.data_out !== want.data_out) begin
                  $error("data_out expected %0h actual %0h", want.data_out, got.data_out);
                  failed = 1'b1;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0h actual %0h", want.status, got.status);
                  failed = 1'b1;
               end
               if (got.entry_count !== want.entry_count) begin
                  $error("entry_count expected %0h actual %0h",
                         want.entry_count, got.entry_count);
                  failed = 1'b1;
               end
            end
         end
         rsp_tready <= !idle_roll();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, first entries, update and the spare code
      push_op(okvt_pkg::FUNC_LOOKUP, key_pool[23], 32'hFFFF_FFFF);
      push_op(okvt_pkg::FUNC_REMOVE, key_pool[23], 32'h0);
      push_op(okvt_pkg::FUNC_INSERT, key_pool[0], 32'hFFFF_FFFF);
      push_op(okvt_pkg::FUNC_INSERT, key_pool[1], 32'h0);
      push_op(okvt_pkg::FUNC_INSERT, key_pool[0], 32'h1234_5678);
      push_op(FUNC_SPARE, key_pool[1], 32'hFFFF_FFFF);
      push_op(okvt_pkg::FUNC_LOOKUP, key_pool[0], 32'h0);
      push_op(okvt_pkg::FUNC_LOOKUP, key_pool[20], 32'h0);
      // fill up to capacity
      for (int i = 2; i < okvt_pkg::DEPTH; i++)
         push_op(okvt_pkg::FUNC_INSERT, key_pool[i], $urandom);
      // full table: new key dropped, existing key still updated
      push_op(okvt_pkg::FUNC_INSERT, key_pool[16], 32'hA5A5_5A5A);
      push_op(okvt_pkg::FUNC_INSERT, key_pool[1], 32'h8000_0001);
      // remove from the middle and from the front, then look past the gap
      push_op(okvt_pkg::FUNC_REMOVE, key_pool[7], 32'h0);
      push_op(okvt_pkg::FUNC_REMOVE, key_pool[0], 32'h0);
      push_op(okvt_pkg::FUNC_LOOKUP, key_pool[8], 32'h0);
      push_op(okvt_pkg::FUNC_REMOVE, key_pool[15], 32'h0);
      wait_drained();

      push_random(600);
      // hold off the sender until the pipeline is empty
      wait_drained();
      push_random(600);
      wait_drained();

      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
